// ===== rtl/core/cle_pkg.sv =====
// ----------------------------------------------------------------------------
// Circular list engine package
// Sizes, operation and status codes, sequencer states and the transfer
// structs shared by the circular list engine, its checker and its testbench.
// ----------------------------------------------------------------------------
package cle_pkg;

  // Number of list slots and the widths that follow from it.
  localparam int CAPACITY = 32;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 32;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Request operation codes.
  typedef enum logic [2:0] {
    OP_INS_AFTER_HEAD = 3'd0,
    OP_LIST_ALL       = 3'd1,
    OP_DEL_VALUE      = 3'd2,
    OP_SEARCH         = 3'd3,
    OP_INS_FRONT      = 3'd4,
    OP_INS_BACK       = 3'd5,
    OP_DEL_FRONT      = 3'd6,
    OP_DEL_BACK       = 3'd7
  } op_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_FOUND   = 3'd1,
    ST_MISSING = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_INS_SLOT,
    S_INS_LINK,
    S_WALK
  } state_t;

  // One request.
  typedef struct packed {
    logic [2:0]                operation;
    logic signed [VALUE_W-1:0] value;
  } cle_in_t;

  // One result.
  typedef struct packed {
    status_t                   status;
    logic signed [VALUE_W-1:0] entry_value;
    logic                      last;
  } cle_out_t;

endpackage

// ===== rtl/core/cle_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered. A read of the
// address being written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module cle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/circular_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// Circular list engine
// Keeps a bounded circular list of signed 32-bit values in slot memories
// (value, link) with a stack of free slots, and runs one list operation per
// request under a small sequencer that walks the links one read per cycle.
//
// Channel   Ports                        Transfer
// request   start, busy, in_item         start high while busy low
// result    out_valid, out_result        every cycle out_valid is high
//
// Timing: a full insert or a request on an empty list answers in the cycle
// after acceptance; an insert passes through S_INS_SLOT and S_INS_LINK;
// search, delete and list walk one linked entry per cycle, visiting at most
// CAPACITY entries, and list all gives one result per cycle, back to back.
// The link memory's registered read sets the walk rate.
// After reset the free-slot stack is filled with every slot index; busy
// stays high meanwhile. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module circular_list_engine_unit
  import cle_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  cle_in_t  in_item,
  output logic     out_valid,
  output cle_out_t out_result
);

  // Control state.
  state_t state_r, state_nxt;
  slot_t  init_idx_r, init_idx_nxt;
  cnt_t   free_top_r, free_top_nxt;
  slot_t  head_r, head_nxt;
  slot_t  tail_r, tail_nxt;
  cnt_t   cnt_r, cnt_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Request context and walk registers.
  op_t                       op_r, op_nxt;
  logic signed [VALUE_W-1:0] val_r, val_nxt;
  slot_t                     cur_r, cur_nxt;
  slot_t                     prev_r, prev_nxt;
  slot_t                     slot_r, slot_nxt;
  cnt_t                      step_r, step_nxt;
  cle_out_t                  out_result_r, out_result_nxt;

  // Memory ports.
  logic               fs_we;
  slot_t              fs_waddr, fs_wdata, fs_raddr, fs_rd;
  logic               lk_we;
  slot_t              lk_waddr, lk_wdata, lk_rd;
  logic               vl_we;
  slot_t              vl_waddr;
  logic [VALUE_W-1:0] vl_wdata, vl_rd;
  slot_t              mem_raddr;

  op_t  in_op;
  logic in_is_insert;
  logic is_last;
  logic hit;

  cle_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_free_stack (
    .clk     (clk),
    .wr_en   (fs_we),
    .wr_addr (fs_waddr),
    .wr_data (fs_wdata),
    .rd_addr (fs_raddr),
    .rd_data (fs_rd)
  );

  cle_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_link_store (
    .clk     (clk),
    .wr_en   (lk_we),
    .wr_addr (lk_waddr),
    .wr_data (lk_wdata),
    .rd_addr (mem_raddr),
    .rd_data (lk_rd)
  );

  cle_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_value_store (
    .clk     (clk),
    .wr_en   (vl_we),
    .wr_addr (vl_waddr),
    .wr_data (vl_wdata),
    .rd_addr (mem_raddr),
    .rd_data (vl_rd)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_result = out_result_r;

  assign in_op        = op_t'(in_item.operation);
  assign in_is_insert = in_op inside {OP_INS_AFTER_HEAD, OP_INS_FRONT, OP_INS_BACK};

  // The top of the free stack is read every cycle; it is used after an insert starts.
  assign fs_raddr = slot_t'(free_top_r - cnt_t'(1));

  // During a walk the next read follows the link just read.
  assign mem_raddr = (state_r == S_WALK) ? lk_rd : head_r;

  assign is_last = ((step_r + cnt_t'(1)) == cnt_r);

  // Match condition for the delete kinds: value, first entry or tail entry.
  always_comb begin
    case (op_r) inside
      OP_DEL_VALUE: hit = (vl_rd == val_r);
      OP_DEL_FRONT: hit = 1'b1;
      default:      hit = is_last;
    endcase
  end

  // Sequencer: next state, list updates and result.
  always_comb begin
    state_nxt      = state_r;
    init_idx_nxt   = init_idx_r;
    free_top_nxt   = free_top_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = 1'b0;
    op_nxt         = op_r;
    val_nxt        = val_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    slot_nxt       = slot_r;
    step_nxt       = step_r;
    out_result_nxt = out_result_r;
    fs_we          = 1'b0;
    fs_waddr       = free_top_r[SLOT_W-1:0];
    fs_wdata       = cur_r;
    lk_we          = 1'b0;
    lk_waddr       = prev_r;
    lk_wdata       = lk_rd;
    vl_we          = 1'b0;
    vl_waddr       = fs_rd;
    vl_wdata       = val_r;

    unique case (state_r)
      // Fill the free stack with every slot index.
      S_INIT: begin
        fs_we        = 1'b1;
        fs_waddr     = init_idx_r;
        fs_wdata     = init_idx_r;
        init_idx_nxt = init_idx_r + slot_t'(1);
        if (init_idx_r == slot_t'(CAPACITY - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      // Take a request; answer full and empty cases at once.
      S_IDLE: begin
        if (start) begin
          op_nxt   = in_op;
          val_nxt  = in_item.value;
          cur_nxt  = head_r;
          prev_nxt = tail_r;
          step_nxt = '0;
          if (in_is_insert) begin
            if (cnt_r == cnt_t'(CAPACITY)) begin
              out_valid_nxt              = 1'b1;
              out_result_nxt.status      = ST_FULL;
              out_result_nxt.entry_value = '0;
              out_result_nxt.last        = 1'b1;
            end else begin
              free_top_nxt = free_top_r - cnt_t'(1);
              state_nxt    = S_INS_SLOT;
            end
          end else if (cnt_r == '0) begin
            out_valid_nxt              = 1'b1;
            out_result_nxt.status      = ST_EMPTY;
            out_result_nxt.entry_value = '0;
            out_result_nxt.last        = 1'b1;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end

      // Popped slot is known: store the value and the new entry's link.
      S_INS_SLOT: begin
        slot_nxt = fs_rd;
        vl_we    = 1'b1;
        vl_waddr = fs_rd;
        vl_wdata = val_r;
        lk_we    = 1'b1;
        lk_waddr = fs_rd;
        if (cnt_r == '0) begin
          lk_wdata = fs_rd;
        end else if (op_r == OP_INS_AFTER_HEAD) begin
          lk_wdata = lk_rd;
        end else begin
          lk_wdata = head_r;
        end
        state_nxt = S_INS_LINK;
      end

      // Hook the new entry into the ring and finish the insert.
      S_INS_LINK: begin
        if (cnt_r == '0) begin
          head_nxt = slot_r;
          tail_nxt = slot_r;
          cnt_nxt  = cnt_t'(1);
        end else begin
          lk_we    = 1'b1;
          lk_wdata = slot_r;
          cnt_nxt  = cnt_r + cnt_t'(1);
          if (op_r == OP_INS_AFTER_HEAD) begin
            lk_waddr = head_r;
            if (head_r == tail_r) begin
              tail_nxt = slot_r;
            end
          end else begin
            lk_waddr = tail_r;
            if (op_r == OP_INS_FRONT) begin
              head_nxt = slot_r;
            end else begin
              tail_nxt = slot_r;
            end
          end
        end
        out_valid_nxt              = 1'b1;
        out_result_nxt.status      = ST_DONE;
        out_result_nxt.entry_value = '0;
        out_result_nxt.last        = 1'b1;
        state_nxt                  = S_IDLE;
      end

      // One linked entry per cycle: value and link of cur_r are on the read ports.
      S_WALK: begin
        cur_nxt  = lk_rd;
        prev_nxt = cur_r;
        step_nxt = step_r + cnt_t'(1);
        out_result_nxt.entry_value = '0;
        out_result_nxt.last        = 1'b1;
        case (op_r) inside
          OP_LIST_ALL: begin
            out_valid_nxt              = 1'b1;
            out_result_nxt.status      = ST_DONE;
            out_result_nxt.entry_value = vl_rd;
            out_result_nxt.last        = is_last;
            if (is_last) begin
              state_nxt = S_IDLE;
            end
          end

          OP_SEARCH: begin
            if (vl_rd == val_r) begin
              out_valid_nxt         = 1'b1;
              out_result_nxt.status = ST_FOUND;
              state_nxt             = S_IDLE;
            end else if (is_last) begin
              out_valid_nxt         = 1'b1;
              out_result_nxt.status = ST_MISSING;
              state_nxt             = S_IDLE;
            end
          end

          OP_DEL_VALUE, OP_DEL_FRONT, OP_DEL_BACK: begin
            if (hit) begin
              // Release the slot onto the free stack.
              fs_we        = 1'b1;
              fs_waddr     = free_top_r[SLOT_W-1:0];
              fs_wdata     = cur_r;
              free_top_nxt = free_top_r + cnt_t'(1);
              if (step_r == '0) begin
                // Removing the head entry.
                if (cnt_r == cnt_t'(1)) begin
                  cnt_nxt  = '0;
                  head_nxt = '0;
                  tail_nxt = '0;
                end else begin
                  head_nxt = lk_rd;
                  lk_we    = 1'b1;
                  lk_waddr = tail_r;
                  lk_wdata = lk_rd;
                  cnt_nxt  = cnt_r - cnt_t'(1);
                end
              end else begin
                // Removing an entry after its predecessor.
                lk_we    = 1'b1;
                lk_waddr = prev_r;
                lk_wdata = lk_rd;
                cnt_nxt  = cnt_r - cnt_t'(1);
                if (cur_r == tail_r) begin
                  tail_nxt = prev_r;
                end
              end
              out_valid_nxt         = 1'b1;
              out_result_nxt.status = ST_DONE;
              state_nxt             = S_IDLE;
            end else if (is_last) begin
              out_valid_nxt         = 1'b1;
              out_result_nxt.status = ST_MISSING;
              state_nxt             = S_IDLE;
            end
          end

          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_idx_r  <= '0;
      free_top_r  <= cnt_t'(CAPACITY);
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_idx_r  <= init_idx_nxt;
      free_top_r  <= free_top_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request context and result payload.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    val_r        <= val_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    slot_r       <= slot_nxt;
    step_r       <= step_nxt;
    out_result_r <= out_result_nxt;
  end

`ifndef SYNTHESIS
  // Between requests every slot is either free or holds an entry.
  a_slot_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |->
      (({1'b0, free_top_r} + {1'b0, cnt_r}) == (CNT_W + 1)'(CAPACITY)))
    else $error("free slots and entries do not add up to the capacity");

  // A walk never visits more entries than the list holds.
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (step_r < cnt_r))
    else $error("list walk ran past the entry count");

  // Every result with a status other than done carries the last mark.
  a_last_on_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_result_r.status != ST_DONE)) |-> out_result_r.last)
    else $error("non-list result without last mark");

  // Listed entries come back to back until the last one.
  a_list_streams: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_result_r.last) |-> (busy ##1 out_valid_r))
    else $error("list transfer interrupted before last entry");

  // No result is produced during the free-stack fill.
  a_no_result_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INIT) |=> !out_valid_r)
    else $error("result during free-stack fill");
`endif

endmodule

// ===== verif/cle_checker.sv =====
// ----------------------------------------------------------------------------
// Circular list engine checker
// Watches the request and result channels of the circular list engine. It
// keeps its own copy of the list, works out the results each accepted
// request must produce, and compares every result transfer field by field
// with the oldest owed result. It reports the failure count and the number
// of results still owed.
// ----------------------------------------------------------------------------
module cle_checker
  import cle_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     busy,
  input  cle_in_t  in_item,
  input  logic     out_valid,
  input  cle_out_t out_result,
  output int       fail_count,
  output int       results_owed
);

  localparam int PRINT_LIMIT = 100;

  // Shadow list, head first, and the results still owed, oldest first.
  logic signed [VALUE_W-1:0] entries_q[$];
  cle_out_t                  owed_results_q[$];
  cle_out_t                  want;

  // Print one line per mismatch (up to a limit) and count every one.
  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_LIMIT) begin
      $display("[%0t] circular_list_engine_unit mismatch: %s", $time, msg);
    end
    fail_count++;
  endtask

  function automatic void owe_result(input status_t st,
                                     input logic signed [VALUE_W-1:0] val,
                                     input logic last);
    cle_out_t r;
    r.status      = st;
    r.entry_value = val;
    r.last        = last;
    owed_results_q.push_back(r);
  endfunction

  // Apply one request to the shadow list and queue the results it causes.
  function automatic void predict_request(input cle_in_t req);
    op_t op;
    int  hit;
    op  = op_t'(req.operation);
    hit = -1;
    case (op)
      OP_INS_AFTER_HEAD, OP_INS_FRONT, OP_INS_BACK: begin
        if (entries_q.size() >= CAPACITY) begin
          owe_result(ST_FULL, '0, 1'b1);
        end else begin
          // An insert into an empty list makes the only entry, whatever its kind.
          if (entries_q.size() == 0 || op == OP_INS_BACK) begin
            entries_q.push_back(req.value);
          end else if (op == OP_INS_FRONT) begin
            entries_q.push_front(req.value);
          end else begin
            entries_q.insert(1, req.value);
          end
          owe_result(ST_DONE, '0, 1'b1);
        end
      end
      default: begin
        if (entries_q.size() == 0) begin
          owe_result(ST_EMPTY, '0, 1'b1);
        end else begin
          case (op)
            OP_LIST_ALL: begin
              foreach (entries_q[i]) begin
                owe_result(ST_DONE, entries_q[i], i == entries_q.size() - 1);
              end
            end
            OP_DEL_VALUE, OP_SEARCH: begin
              // Only the first match from the head counts.
              foreach (entries_q[i]) begin
                if (hit < 0 && entries_q[i] == req.value) hit = i;
              end
              if (hit < 0) begin
                owe_result(ST_MISSING, '0, 1'b1);
              end else if (op == OP_SEARCH) begin
                owe_result(ST_FOUND, '0, 1'b1);
              end else begin
                entries_q.delete(hit);
                owe_result(ST_DONE, '0, 1'b1);
              end
            end
            OP_DEL_FRONT: begin
              void'(entries_q.pop_front());
              owe_result(ST_DONE, '0, 1'b1);
            end
            default: begin
              void'(entries_q.pop_back());
              owe_result(ST_DONE, '0, 1'b1);
            end
          endcase
        end
      end
    endcase
  endfunction

  // Check result transfers first: no result can belong to a request
  // accepted at the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      entries_q.delete();
      owed_results_q.delete();
    end else begin
      if (out_valid) begin
        if (owed_results_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result: status %0d value %0d last %0b",
                                    out_result.status, out_result.entry_value,
                                    out_result.last));
        end else begin
          want = owed_results_q.pop_front();
          if (out_result.status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_result.status, want.status));
          end
          if (out_result.entry_value !== want.entry_value) begin
            report_mismatch($sformatf("entry_value %0d, expected %0d",
                                      out_result.entry_value, want.entry_value));
          end
          if (out_result.last !== want.last) begin
            report_mismatch($sformatf("last %0b, expected %0b",
                                      out_result.last, want.last));
          end
        end
      end
      if (start && !busy) predict_request(in_item);
    end
    results_owed = owed_results_q.size();
  end

endmodule

// ===== verif/tb_circular_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// Circular list engine testbench
// Drives directed requests covering empty, one-entry, duplicate and full
// lists, then random phases that fill, drain and mix the list under varying
// sender idling. The checker beside the block predicts and compares; this
// top makes the stimulus, runs the watchdog and gives the verdict.
// ----------------------------------------------------------------------------
module tb_circular_list_engine_unit;
  import cle_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 2 * CAPACITY + 8;
  localparam int PHASE_ITEMS    = 57;
  localparam int PHASE_COUNT    = 7;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_ANY} traffic_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     start;
  logic     busy;
  cle_in_t  in_item;
  logic     out_valid;
  cle_out_t out_result;

  int fail_count;
  int results_owed;
  int stall_cycles;
  int sender_idle_pct;

  logic signed [VALUE_W-1:0] value_pool [0:7];
  int       idle_plan [0:PHASE_COUNT-1] = '{0, 84, 20, 0, 84, 20, 50};
  traffic_t mix_plan  [0:PHASE_COUNT-1] = '{MIX_DRAIN, MIX_FILL, MIX_ANY, MIX_DRAIN,
                                            MIX_FILL, MIX_DRAIN, MIX_ANY};

  circular_list_engine_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_result(out_result)
  );

  cle_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_result  (out_result),
    .fail_count  (fail_count),
    .results_owed(results_owed)
  );

  always #4 clk = ~clk;

  // Watchdog: end the run if nothing transfers for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("** circular_list_engine_unit: FAILED **");
      $finish;
    end
  end

  // Present one request after a random idle gap and hold it until the
  // transfer happens.
  task automatic send(input op_t op, input logic signed [VALUE_W-1:0] val);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    start   <= 1'b1;
    in_item <= '{operation: 3'(op), value: val};
    do @(posedge clk); while (busy);
  endtask

  // Stop sending until every owed result has come back.
  task automatic hold_until_drained();
    start <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
    @(posedge clk);
  endtask

  // Mostly pool values, so searches and deletes hit; the rest fully random.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    if ($urandom_range(99) < 65) return value_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  function automatic op_t insert_kind();
    case ($urandom_range(2))
      0:       return OP_INS_AFTER_HEAD;
      1:       return OP_INS_FRONT;
      default: return OP_INS_BACK;
    endcase
  endfunction

  initial begin
    op_t op;
    int  roll;

    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_item <= '0;
    sender_idle_pct = 0;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Every non-insert request kind on an empty list.
    send(OP_LIST_ALL, 0);
    send(OP_DEL_FRONT, 0);
    send(OP_DEL_BACK, 0);
    send(OP_DEL_VALUE, 7);
    send(OP_SEARCH, 7);
    // Build a list with extremes and a duplicate.
    send(OP_INS_AFTER_HEAD, 32'h8000_0000);
    send(OP_INS_AFTER_HEAD, 32'h7fff_ffff);
    send(OP_INS_FRONT, 0);
    send(OP_INS_BACK, -1);
    send(OP_INS_AFTER_HEAD, 5);
    send(OP_INS_BACK, 5);
    send(OP_LIST_ALL, 0);
    send(OP_SEARCH, 5);
    send(OP_SEARCH, 12345);
    send(OP_DEL_VALUE, 12345);
    send(OP_DEL_VALUE, 5);
    send(OP_LIST_ALL, 0);
    send(OP_DEL_BACK, 0);
    send(OP_DEL_FRONT, 0);
    // Remove the tail by value, then the head by value.
    send(OP_DEL_VALUE, -1);
    send(OP_DEL_VALUE, 32'h8000_0000);
    send(OP_DEL_BACK, 0);
    send(OP_INS_BACK, 42);
    send(OP_LIST_ALL, 0);
    send(OP_DEL_FRONT, 0);
    hold_until_drained();

    // Fill from empty past capacity so every insert kind meets a full list.
    sender_idle_pct = 20;
    repeat (CAPACITY + 2) send(insert_kind(), pick_value());
    send(OP_INS_AFTER_HEAD, pick_value());
    send(OP_INS_FRONT, pick_value());
    send(OP_INS_BACK, pick_value());
    send(OP_LIST_ALL, 0);
    hold_until_drained();

    // Random phases, each biased toward growing, shrinking or mixing.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      sender_idle_pct = idle_plan[p];
      repeat (PHASE_ITEMS) begin
        roll = $urandom_range(99);
        case (mix_plan[p])
          MIX_FILL: begin
            op = (roll < 80) ? insert_kind() :
                 (roll < 90) ? OP_LIST_ALL :
                 (roll < 95) ? OP_SEARCH : OP_DEL_VALUE;
          end
          MIX_DRAIN: begin
            op = (roll < 30) ? OP_DEL_FRONT :
                 (roll < 55) ? OP_DEL_BACK :
                 (roll < 75) ? OP_DEL_VALUE :
                 (roll < 85) ? OP_SEARCH :
                 (roll < 93) ? OP_LIST_ALL : insert_kind();
          end
          default: op = op_t'($urandom_range(7));
        endcase
        send(op, pick_value());
      end
      hold_until_drained();
    end

    // Let any stray result show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("** circular_list_engine_unit: PASSED **");
    end else begin
      $display("** circular_list_engine_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/cle_pkg.sv
rtl/core/cle_ram.sv
rtl/core/circular_list_engine_unit.sv
verif/cle_checker.sv
verif/tb_circular_list_engine_unit.sv
